>>> rtl/hicdf_pkg.sv
// ---------------------------------------------------------------------------
// Histogram inverse-CDF sampler package
// Shared constants, command codes, state type and divider response type.
// ---------------------------------------------------------------------------
package hicdf_pkg;

    localparam int CMD_W  = 2;
    localparam int IDX_W  = 8;
    localparam int FRAC_W = 16;
    localparam int BW_W   = 32;   // bin weight width
    localparam int SUM_W  = 40;   // prefix sum and total width

    localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_BUILD = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY = 2'd3;

    localparam logic ST_OK      = 1'b0;
    localparam logic ST_NO_DIST = 1'b1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_BUILD,
        S_MUL,
        S_SEARCH,
        S_CMP,
        S_W_DATA,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic              done;
        logic [FRAC_W-1:0] quot;
    } t_div_rsp;

endpackage

>>> rtl/hicdf_if.sv
// ---------------------------------------------------------------------------
// Histogram sampler channels
// Command channel and result channel, each with valid/ready handshake.
// ---------------------------------------------------------------------------
interface hicdf_in_if;
    import hicdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  bin_index;
    logic [FRAC_W-1:0] weight;
    logic [FRAC_W-1:0] sample_fraction;

    modport source (output valid, command, bin_index, weight, sample_fraction, input ready);
    modport sink   (input valid, command, bin_index, weight, sample_fraction, output ready);
endinterface

interface hicdf_out_if;
    import hicdf_pkg::*;
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  chosen_bin;
    logic [FRAC_W-1:0] probability;
    logic              status;

    modport source (output valid, chosen_bin, probability, status, input ready);
    modport sink   (input valid, chosen_bin, probability, status, output ready);
endinterface

>>> rtl/histogram_inverse_cdf_sampler.sv
// ---------------------------------------------------------------------------
// Histogram inverse-CDF sampler
// Weighted histogram with prefix-sum build, inverse-CDF draws and queries.
// ---------------------------------------------------------------------------
// The block holds BINS bin weights in one RAM and their prefix sums in a
// second. It works on one command at a time and gives one result per command.
// After reset a clearing pass writes zero to every bin weight, during which
// no command is taken. An add-weight reads the bin, then adds with saturation
// and writes back, then gives its result. A build walks every bin through
// the weight RAM read port, one bin a cycle. A draw multiplies u by the
// total, then runs a binary search over the prefix-sum RAM, each step a read
// and then a compare, then reads the chosen weight and divides it by the
// total in a bit-serial divider. A query skips the search. A finished result
// sits in an output register, so the next command is taken while the result
// waits for its transfer.
// ---------------------------------------------------------------------------
module histogram_inverse_cdf_sampler #(
    parameter int BINS = 256
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    hicdf_in_if.sink     i_cmd,
    hicdf_out_if.source  o_res
);
    import hicdf_pkg::*;

    localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CNT_END  = CW'(BINS);
    localparam logic [CW-1:0] CNT_LAST = CW'(BINS - 1);

    t_state            r_state, n_state;
    logic [CMD_W-1:0]  r_cmd, n_cmd;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic              r_in_range, n_in_range;
    logic [FRAC_W-1:0] r_w, n_w;
    logic [FRAC_W-1:0] r_u, n_u;
    logic [SUM_W-1:0]  r_total, n_total;
    logic [SUM_W-1:0]  r_acc, n_acc;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_pv, n_pv;
    logic [AW-1:0]     r_paddr, n_paddr;
    logic [AW-1:0]     r_lo, n_lo;
    logic [AW-1:0]     r_hi, n_hi;
    logic [AW-1:0]     r_mid, n_mid;
    logic [55:0]       r_target, n_target;
    logic [IDX_W-1:0]  r_res_bin, n_res_bin;
    logic [FRAC_W-1:0] r_res_prob, n_res_prob;
    logic              r_res_st, n_res_st;
    logic              r_out_valid, n_out_valid;
    logic [IDX_W-1:0]  r_out_bin, n_out_bin;
    logic [FRAC_W-1:0] r_out_prob, n_out_prob;
    logic              r_out_st, n_out_st;

    logic              w_we;
    logic [AW-1:0]     w_waddr, w_raddr;
    logic [BW_W-1:0]   w_wdata, w_rdata;
    logic              p_we;
    logic [AW-1:0]     p_waddr, p_raddr;
    logic [SUM_W-1:0]  p_wdata, p_rdata;

    logic              div_start;
    t_div_rsp          div_rsp;

    logic              in_xfer;
    logic [BW_W:0]     add_sum;
    logic [SUM_W:0]    acc_sum;
    logic [SUM_W-1:0]  acc_sat;
    logic [AW:0]       mid_sum;
    logic [55:0]       product;

    hicdf_ram #(.WIDTH(BW_W), .DEPTH(BINS)) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    hicdf_ram #(.WIDTH(SUM_W), .DEPTH(BINS)) u_prefix_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    hicdf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (w_rdata),
        .i_den   (r_total),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_cnt       <= '0;
            r_pv        <= 1'b0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pv        <= n_pv;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
        r_cmd      <= n_cmd;
        r_idx      <= n_idx;
        r_in_range <= n_in_range;
        r_w        <= n_w;
        r_u        <= n_u;
        r_acc      <= n_acc;
        r_paddr    <= n_paddr;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_mid      <= n_mid;
        r_target   <= n_target;
        r_res_bin  <= n_res_bin;
        r_res_prob <= n_res_prob;
        r_res_st   <= n_res_st;
        r_out_bin  <= n_out_bin;
        r_out_prob <= n_out_prob;
        r_out_st   <= n_out_st;
    end

    assign in_xfer = i_cmd.valid && i_cmd.ready;
    assign add_sum = {1'b0, w_rdata} + (BW_W + 1)'(r_w);
    assign acc_sum = {1'b0, r_acc} + (SUM_W + 1)'(w_rdata);
    assign acc_sat = acc_sum[SUM_W] ? '1 : acc_sum[SUM_W-1:0];
    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign product = r_u * r_total;

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_in_range  = r_in_range;
        n_w         = r_w;
        n_u         = r_u;
        n_total     = r_total;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_pv        = 1'b0;
        n_paddr     = r_paddr;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_target    = r_target;
        n_res_bin   = r_res_bin;
        n_res_prob  = r_res_prob;
        n_res_st    = r_res_st;
        n_out_bin   = r_out_bin;
        n_out_prob  = r_out_prob;
        n_out_st    = r_out_st;
        n_out_valid = r_out_valid && !o_res.ready;

        w_we      = 1'b0;
        w_waddr   = AW'(r_idx);
        w_wdata   = '0;
        w_raddr   = AW'(i_cmd.bin_index);
        p_we      = 1'b0;
        p_waddr   = r_paddr;
        p_wdata   = acc_sat;
        p_raddr   = mid_sum[AW:1];
        div_start = 1'b0;

        case (r_state)
            S_CLEAR: begin
                // Zero every bin weight after reset.
                w_we    = 1'b1;
                w_waddr = r_cnt[AW-1:0];
                n_cnt   = r_cnt + CW'(1);
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd      = i_cmd.command;
                    n_idx      = i_cmd.bin_index;
                    n_w        = i_cmd.weight;
                    n_u        = i_cmd.sample_fraction;
                    n_in_range = {24'h0, i_cmd.bin_index} < 32'(BINS);
                    n_res_bin  = i_cmd.bin_index;
                    n_res_prob = '0;
                    n_res_st   = ST_OK;
                    case (i_cmd.command)
                        CMD_ADD: begin
                            n_state = n_in_range ? S_ADD_RD : S_DONE;
                        end
                        CMD_BUILD: begin
                            n_res_bin = '0;
                            n_cnt     = '0;
                            n_acc     = '0;
                            n_state   = S_BUILD;
                        end
                        CMD_DRAW: begin
                            n_res_bin = '0;
                            if (r_total == '0) begin
                                n_res_st = ST_NO_DIST;
                                n_state  = S_DONE;
                            end else begin
                                n_state = S_MUL;
                            end
                        end
                        default: begin
                            // Query: the weight read is issued on this edge.
                            if (r_total == '0) begin
                                n_res_st = ST_NO_DIST;
                                n_state  = S_DONE;
                            end else if (!n_in_range) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_W_DATA;
                            end
                        end
                    endcase
                end
            end
            S_ADD_RD: begin
                // Read data is back: saturating add and write-back.
                w_we    = 1'b1;
                w_wdata = add_sum[BW_W] ? '1 : add_sum[BW_W-1:0];
                n_state = S_DONE;
            end
            S_BUILD: begin
                // Reads run one bin ahead of the accumulate and prefix write.
                w_raddr = r_cnt[AW-1:0];
                if (r_cnt != CNT_END) begin
                    n_cnt   = r_cnt + CW'(1);
                    n_pv    = 1'b1;
                    n_paddr = r_cnt[AW-1:0];
                end
                if (r_pv) begin
                    p_we  = 1'b1;
                    n_acc = acc_sat;
                end
                if (r_cnt == CNT_END && !r_pv) begin
                    if (r_acc == '0) begin
                        n_res_st = ST_NO_DIST;
                    end else begin
                        n_total = r_acc;
                    end
                    n_state = S_DONE;
                end
            end
            S_MUL: begin
                n_target = product;
                n_lo     = '0;
                n_hi     = AW'(BINS - 1);
                n_state  = S_SEARCH;
            end
            S_SEARCH: begin
                // Search ends when the bounds meet; a miss lands on the last bin.
                if (r_lo == r_hi) begin
                    w_raddr   = r_lo;
                    n_res_bin = IDX_W'(r_lo);
                    n_state   = S_W_DATA;
                end else begin
                    n_mid   = mid_sum[AW:1];
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if ({p_rdata, 16'h0} >= r_target) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + AW'(1);
                end
                n_state = S_SEARCH;
            end
            S_W_DATA: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_res_prob = div_rsp.quot;
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_out_valid = 1'b1;
                    n_out_bin   = r_res_bin;
                    n_out_prob  = r_res_prob;
                    n_out_st    = r_res_st;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign i_cmd.ready       = (r_state == S_IDLE);
    assign o_res.valid       = r_out_valid;
    assign o_res.chosen_bin  = r_out_bin;
    assign o_res.probability = r_out_prob;
    assign o_res.status      = r_out_st;

    // Only one command is in flight: a transfer drops ready on the next cycle.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_cmd.ready)
        else $error("command taken while another was in flight");

    // The divider answers only while the sequencer waits for it.
    a_div_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == S_DIV))
        else $error("divider result outside the divide state");

    // A missing distribution never comes with a non-zero probability.
    a_no_dist_prob: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.status) |-> (o_res.probability == '0))
        else $error("probability given without a distribution");

    // Weight writes in normal operation happen only as the second step of an add.
    a_add_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD_RD) |-> ($past(in_xfer) && (r_cmd == CMD_ADD)))
        else $error("weight write-back without an add command");

endmodule

>>> rtl/hicdf_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module hicdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/hicdf_div.sv
// ---------------------------------------------------------------------------
// Ratio divider
// Computes weight * 2^16 / total, one quotient bit a cycle, saturated.
// ---------------------------------------------------------------------------
module hicdf_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [hicdf_pkg::BW_W-1:0]    i_num,
    input  logic [hicdf_pkg::SUM_W-1:0]   i_den,
    output hicdf_pkg::t_div_rsp           o_rsp
);
    import hicdf_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [4:0]        r_cnt, n_cnt;
    logic [SUM_W-1:0]  r_rem, n_rem;
    logic [SUM_W-1:0]  r_den, n_den;
    logic [FRAC_W-1:0] r_quot, n_quot;
    logic [SUM_W:0]    w_rem2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt  <= n_cnt;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
    end

    assign w_rem2 = {r_rem, 1'b0};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quot = r_quot;
        if (i_start) begin
            n_den = i_den;
            n_rem = SUM_W'(i_num);
            n_cnt = 5'd0;
            // A weight not below the total gives a ratio of one or more.
            if (SUM_W'(i_num) >= i_den) begin
                n_quot = '1;
                n_done = 1'b1;
            end else begin
                n_quot = '0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            if (w_rem2 >= {1'b0, r_den}) begin
                n_rem  = SUM_W'(w_rem2 - {1'b0, r_den});
                n_quot = {r_quot[FRAC_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rem2[SUM_W-1:0];
                n_quot = {r_quot[FRAC_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 5'd1;
            if (r_cnt == 5'(FRAC_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
endmodule

>>> sim/hicdf_tb_if.sv
// ---------------------------------------------------------------------------
// Sampler testbench channel notes
// The block's own channel interfaces are used; this file only adds nothing
// but a small shared record type for the checker.
// ---------------------------------------------------------------------------
package hicdf_tb_pkg;
    import hicdf_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0]  chosen_bin;
        logic [FRAC_W-1:0] probability;
        logic              status;
    } t_sample_result;
endpackage

>>> sim/hicdf_checker.sv
// ---------------------------------------------------------------------------
// Sampler result checker
// Watches both channels, predicts each result and compares it field by field.
// ---------------------------------------------------------------------------
module hicdf_checker #(
    parameter int BINS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hicdf_in_if         i_cmd,
    hicdf_out_if        i_res,
    output int          o_errors,
    output int          o_pending
);
    import hicdf_pkg::*;
    import hicdf_tb_pkg::*;

    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    logic [BW_W-1:0]  bin_weight [BINS];
    logic [SUM_W-1:0] prefix     [BINS];
    logic [SUM_W-1:0] total;
    t_sample_result   expected_results [$];

    function automatic logic [FRAC_W-1:0] share_of_total(logic [BW_W-1:0] w);
        logic [63:0] q;
        if (total == '0) return '0;
        q = {w, 16'h0} / {24'h0, total};
        return (q > 64'hFFFF) ? 16'hFFFF : q[FRAC_W-1:0];
    endfunction

    task automatic predict(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                           logic [FRAC_W-1:0] w, logic [FRAC_W-1:0] u);
        t_sample_result r;
        logic [SUM_W:0] acc;
        logic [63:0]    target;
        int             pick;
        logic           none;
        none = (total == '0);
        r = '0;
        case (cmd)
            CMD_ADD: begin
                if (idx < BINS) begin
                    bin_weight[idx] = ({1'b0, bin_weight[idx]} + w > {1'b0, {BW_W{1'b1}}})
                                      ? {BW_W{1'b1}} : bin_weight[idx] + w;
                end
                r.chosen_bin = idx;
            end
            CMD_BUILD: begin
                acc = '0;
                for (int i = 0; i < BINS; i++) begin
                    acc = acc + bin_weight[i];
                    if (acc > SUM_MAX) acc = SUM_MAX;
                end
                if (acc == '0) begin
                    r.status = ST_NO_DIST;
                end else begin
                    acc = '0;
                    for (int i = 0; i < BINS; i++) begin
                        acc = acc + bin_weight[i];
                        if (acc > SUM_MAX) acc = SUM_MAX;
                        prefix[i] = acc[SUM_W-1:0];
                    end
                    total = acc[SUM_W-1:0];
                end
            end
            CMD_DRAW: begin
                if (none) begin
                    r.status = ST_NO_DIST;
                end else begin
                    target = u * {24'h0, total};
                    pick = BINS - 1;
                    for (int i = 0; i < BINS; i++) begin
                        if ({prefix[i], 16'h0} >= target) begin
                            pick = i;
                            break;
                        end
                    end
                    r.chosen_bin  = pick[IDX_W-1:0];
                    r.probability = share_of_total(bin_weight[pick]);
                end
            end
            default: begin
                r.chosen_bin = idx;
                r.status     = none;
                if (!none && idx < BINS) r.probability = share_of_total(bin_weight[idx]);
            end
        endcase
        expected_results.push_back(r);
    endtask

    task automatic report(string what);
        $display("mismatch at %0t: %s", $time, what);
        o_errors++;
    endtask

    assign o_pending = expected_results.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        t_sample_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < BINS; i++) begin
                bin_weight[i] = '0;
                prefix[i]     = '0;
            end
            total = '0;
            expected_results.delete();
        end else begin
            if (i_cmd.valid && i_cmd.ready)
                predict(i_cmd.command, i_cmd.bin_index, i_cmd.weight, i_cmd.sample_fraction);
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    report("result with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.chosen_bin !== want.chosen_bin)
                        report($sformatf("chosen_bin %0d, expected %0d",
                                         i_res.chosen_bin, want.chosen_bin));
                    if (i_res.probability !== want.probability)
                        report($sformatf("probability %0d, expected %0d",
                                         i_res.probability, want.probability));
                    if (i_res.status !== want.status)
                        report($sformatf("status %0b, expected %0b",
                                         i_res.status, want.status));
                end
            end
        end
    end

endmodule

>>> sim/histogram_inverse_cdf_sampler_tb.sv
// ---------------------------------------------------------------------------
// Histogram inverse-CDF sampler testbench
// Drives directed and random command streams with bursty sending and a
// stalling receiver; a separate checker predicts and compares every result.
// ---------------------------------------------------------------------------
module histogram_inverse_cdf_sampler_tb;
    import hicdf_pkg::*;

    localparam int  BINS        = 256;
    localparam int  RANDOM_CMDS = 600;
    localparam longint CYCLE_LIMIT = 2000000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    int     errors;
    int     pending;
    longint cycles = 0;
    logic   stall_pattern_on = 1'b0;

    hicdf_in_if  cmd_ch ();
    hicdf_out_if res_ch ();

    histogram_inverse_cdf_sampler #(.BINS(BINS)) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (cmd_ch.sink),
        .o_res  (res_ch.source)
    );

    hicdf_checker #(.BINS(BINS)) i_checker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd_ch),
        .i_res    (res_ch),
        .o_errors (errors),
        .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The cycle counter is the only guard against a hung block. The limit
    // covers the clearing pass, a full build for every command, and the
    // sender's and receiver's longest pauses, several times.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // The receiver stalls on a pattern of its own: long stretches where it is
    // always ready alternate with stretches of random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else begin
            if (cycles % 500 == 0) stall_pattern_on <= ~stall_pattern_on;
            res_ch.ready <= stall_pattern_on ? ($urandom_range(0, 3) != 0) : 1'b1;
        end
    end

    // One command transfer. The valid stays high from one transfer to the
    // next within a burst, so it is only lowered when a gap is due.
    task automatic send(logic [CMD_W-1:0] cmd, logic [IDX_W-1:0] idx,
                        logic [FRAC_W-1:0] w, logic [FRAC_W-1:0] u);
        cmd_ch.valid           <= 1'b1;
        cmd_ch.command         <= cmd;
        cmd_ch.bin_index       <= idx;
        cmd_ch.weight          <= w;
        cmd_ch.sample_fraction <= u;
        do @(posedge i_clk); while (!cmd_ch.ready);
    endtask

    task automatic gap(int n);
        cmd_ch.valid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Draws a random command; most random traffic builds a distribution and
    // samples it, so that the draw search reaches every depth of the cdf.
    task automatic send_random();
        int                pick;
        logic [IDX_W-1:0]  idx;
        logic [FRAC_W-1:0] w;
        pick = int'($urandom_range(0, 99));
        idx  = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 7))
                                           : IDX_W'($urandom);
        w    = ($urandom_range(0, 9) == 0) ? 16'hFFFF : FRAC_W'($urandom);
        if (pick < 35)      send(CMD_ADD, idx, w, FRAC_W'($urandom));
        else if (pick < 42) send(CMD_BUILD, IDX_W'($urandom), FRAC_W'($urandom),
                                 FRAC_W'($urandom));
        else if (pick < 80) send(CMD_DRAW, IDX_W'($urandom), FRAC_W'($urandom),
                                 FRAC_W'($urandom));
        else                send(CMD_QUERY, idx, FRAC_W'($urandom), FRAC_W'($urandom));
    endtask

    initial begin
        int left;
        cmd_ch.valid           <= 1'b0;
        cmd_ch.command         <= CMD_ADD;
        cmd_ch.bin_index       <= '0;
        cmd_ch.weight          <= '0;
        cmd_ch.sample_fraction <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Nothing captured yet: draw, query and an empty build all report
        // that there is no distribution.
        send(CMD_DRAW, 8'h00, 16'h0000, 16'hFFFF);
        send(CMD_QUERY, 8'hFF, 16'hFFFF, 16'h0000);
        send(CMD_BUILD, 8'h00, 16'h0000, 16'h0000);
        // A few bins, including both ends, then a real build.
        send(CMD_ADD, 8'h00, 16'hFFFF, 16'h0000);
        send(CMD_ADD, 8'hFF, 16'h0001, 16'h0000);
        send(CMD_ADD, 8'h80, 16'h0000, 16'h0000);
        send(CMD_ADD, 8'h55, 16'hAAAA, 16'h5555);
        send(CMD_BUILD, 8'hFF, 16'hFFFF, 16'hFFFF);
        // Draws at both ends of u, and queries of a full bin and an empty one.
        send(CMD_DRAW, 8'h00, 16'h0000, 16'h0000);
        send(CMD_DRAW, 8'h00, 16'h0000, 16'hFFFF);
        send(CMD_DRAW, 8'hAA, 16'h5555, 16'h8000);
        send(CMD_QUERY, 8'h00, 16'h0000, 16'h0000);
        send(CMD_QUERY, 8'h80, 16'h0000, 16'h0000);
        // Weights changed after the build are seen by the next query, and a
        // bin above the captured total saturates the ratio.
        send(CMD_ADD, 8'h00, 16'hFFFF, 16'h0000);
        send(CMD_ADD, 8'h00, 16'hFFFF, 16'h0000);
        send(CMD_QUERY, 8'h00, 16'h0000, 16'h0000);
        send(CMD_DRAW, 8'h00, 16'h0000, 16'h0001);
        gap(1);

        // Hold off until every expected result is back.
        while (pending != 0) @(posedge i_clk);

        left = RANDOM_CMDS;
        while (left > 0) begin
            for (int n = $urandom_range(1, 12); n > 0 && left > 0; n--) begin
                send_random();
                left--;
            end
            if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 40));
        end
        gap(1);

        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/hicdf_pkg.sv
rtl/hicdf_if.sv
rtl/hicdf_ram.sv
rtl/hicdf_div.sv
rtl/histogram_inverse_cdf_sampler.sv
sim/hicdf_tb_if.sv
sim/hicdf_checker.sv
sim/histogram_inverse_cdf_sampler_tb.sv
